[rtl/idw_pkg.sv]
`default_nettype none

package idw_pkg;

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_RATIO   = 9'b000000010,
        ST_POW_MUL = 9'b000000100,
        ST_POW_SCL = 9'b000001000,
        ST_WMUL    = 9'b000010000,
        ST_ACC     = 9'b000100000,
        ST_QLOAD   = 9'b001000000,
        ST_QDIV    = 9'b010000000,
        ST_QOUT    = 9'b100000000
    } idw_state_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_MAX_COUNT    = 2'd0;
    localparam logic [1:0] REG_MAX_DISTANCE = 2'd1;
    localparam logic [1:0] REG_EXPONENT     = 2'd2;

    localparam logic [6:0]  MAX_STATIONS     = 7'd64;
    localparam logic [6:0]  MAX_COUNT_RST    = 7'd8;
    localparam logic [31:0] MAX_DISTANCE_RST = 32'hFFFF_FFFF;
    localparam logic [2:0]  EXPONENT_RST     = 3'd2;
    localparam logic [2:0]  EXPONENT_MAX     = 3'd4;

    // The distance ratio is 100 / distance; 100 takes seven bits.
    localparam int unsigned SCALE_BITS = 7;
    localparam logic [6:0]  SCALE_NUM  = 7'd100;

    localparam logic [31:0] CAP32      = 32'hFFFF_FFFF;
    localparam logic [63:0] SUM_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SUM_MIN    = 64'h8000_0000_0000_0000;
    localparam logic [6:0]  QUOT_STEPS = 7'd64;

endpackage

`default_nettype wire

[rtl/inverse_distance_weighting.sv]
`default_nettype none

// Channel        Ports                                  Handshake
// -------------  -------------------------------------  ----------------------------
// station in     distance, ion_value, last              start high while busy low
// result out     estimate, used_count, no_station       done high for one cycle
// configuration  wr_en, wr_index, wr_data               wr_en high, taken at once
//
// An accepted station runs the ratio division, raises the ratio to the power k (the
// exponent capped at four) and accumulates; the ratio division is skipped for zero
// distance or k = 0. One shared restoring divider (one quotient bit a cycle) and one
// shared 33 x 33 multiplier do the work. An ignored station that is not last leaves the
// sequencer idle; a last record runs the final 64-step division when a station was used.
// Reset clears sequencer and sums and loads register defaults; the receiver cannot stall.

module inverse_distance_weighting #(
    parameter int unsigned FRACTION_BITS = 16
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    output logic               busy,
    input  wire        [31:0]  distance,
    input  wire signed [31:0]  ion_value,
    input  wire                last,
    output logic               done,
    output logic signed [31:0] estimate,
    output logic        [6:0]  used_count,
    output logic               no_station,
    input  wire                wr_en,
    input  wire        [1:0]   wr_index,
    input  wire        [31:0]  wr_data
);

    localparam int unsigned RATIO_BITS  = idw_pkg::SCALE_BITS + 2 * FRACTION_BITS;
    localparam logic [6:0]  RATIO_STEPS = 7'(RATIO_BITS);
    localparam logic [63:0] RATIO_NUM   = 64'(idw_pkg::SCALE_NUM) << (2 * FRACTION_BITS);
    localparam logic [63:0] RATIO_LOAD  = RATIO_NUM << (64 - RATIO_BITS);
    localparam logic [31:0] WEIGHT_ONE  = 32'd1 << FRACTION_BITS;

    idw_pkg::idw_state_t state_reg, state_next;

    logic [6:0]  max_count_reg;
    logic [31:0] max_distance_reg;
    logic [2:0]  exponent_reg;

    logic [6:0]  count_reg, count_next;
    logic        stopped_reg, stopped_next;
    logic [63:0] wsum_reg, wsum_next;
    logic [63:0] vsum_reg, vsum_next;
    logic        done_reg, done_next;

    logic signed [31:0] ion_reg, ion_next;
    logic        last_reg, last_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] w_reg, w_next;
    logic [2:0]  k_reg, k_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] div_q_reg, div_q_next;
    logic [63:0] div_r_reg, div_r_next;
    logic [63:0] div_d_reg, div_d_next;
    logic [6:0]  div_cnt_reg, div_cnt_next;
    logic        neg_reg, neg_next;
    logic signed [31:0] est_reg, est_next;
    logic [6:0]  used_reg, used_next;
    logic        nost_reg, nost_next;

    // Shared divider step.
    logic [63:0] rem_shift;
    logic [64:0] rem_diff;
    logic [63:0] step_q, step_r;

    always_comb
    begin
        rem_shift = {div_r_reg[62:0], div_q_reg[63]};
        rem_diff  = {1'b0, rem_shift} - {1'b0, div_d_reg};
        if (!rem_diff[64])
        begin
            step_r = rem_diff[63:0];
            step_q = {div_q_reg[62:0], 1'b1};
        end
        else
        begin
            step_r = rem_shift;
            step_q = {div_q_reg[62:0], 1'b0};
        end
    end

    // Shared multiplier.
    logic [31:0]        w_fix;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    assign w_fix = (w_reg == 32'd0) ? 32'd1 : w_reg;

    always_comb
    begin
        if (state_reg == idw_pkg::ST_WMUL)
        begin
            mul_a = $signed({1'b0, w_fix});
            mul_b = $signed({ion_reg[31], ion_reg});
        end
        else
        begin
            mul_a = $signed({1'b0, w_reg});
            mul_b = $signed({1'b0, r_reg});
        end
    end

    assign mul_p = mul_a * mul_b;

    // Accumulators and helpers.
    logic [6:0]  limit;
    logic        accept;
    logic [2:0]  k_cap;
    logic [63:0] scaled;
    logic [64:0] wsum_add;
    logic [64:0] vsum_add;
    logic [63:0] mag;

    always_comb
    begin
        limit    = (max_count_reg > idw_pkg::MAX_STATIONS) ? idw_pkg::MAX_STATIONS
                                                            : max_count_reg;
        accept   = (count_reg < limit) && (distance <= max_distance_reg);
        k_cap    = (exponent_reg > idw_pkg::EXPONENT_MAX) ? idw_pkg::EXPONENT_MAX
                                                           : exponent_reg;
        scaled   = prod_reg >> FRACTION_BITS;
        wsum_add = {1'b0, wsum_reg} + {33'd0, w_reg};
        vsum_add = {vsum_reg[63], vsum_reg} + {prod_reg[63], prod_reg};
        mag      = vsum_reg[63] ? (64'd0 - vsum_reg) : vsum_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        stopped_next = stopped_reg;
        wsum_next    = wsum_reg;
        vsum_next    = vsum_reg;
        done_next    = 1'b0;
        ion_next     = ion_reg;
        last_next    = last_reg;
        r_next       = r_reg;
        w_next       = w_reg;
        k_next       = k_reg;
        prod_next    = prod_reg;
        div_q_next   = div_q_reg;
        div_r_next   = div_r_reg;
        div_d_next   = div_d_reg;
        div_cnt_next = div_cnt_reg;
        neg_next     = neg_reg;
        est_next     = est_reg;
        used_next    = used_reg;
        nost_next    = nost_reg;

        case (state_reg)
            idw_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    ion_next  = ion_value;
                    last_next = last;
                    if (!stopped_reg && accept)
                    begin
                        k_next = k_cap;
                        w_next = WEIGHT_ONE;
                        if (k_cap == 3'd0 || distance == 32'd0)
                        begin
                            r_next     = idw_pkg::CAP32;
                            state_next = idw_pkg::ST_POW_MUL;
                        end
                        else
                        begin
                            div_q_next   = RATIO_LOAD;
                            div_r_next   = 64'd0;
                            div_d_next   = {32'd0, distance};
                            div_cnt_next = RATIO_STEPS;
                            state_next   = idw_pkg::ST_RATIO;
                        end
                    end
                    else
                    begin
                        // A station that fails the tests ends accumulation for the set.
                        stopped_next = 1'b1;
                        if (last)
                        begin
                            state_next = idw_pkg::ST_QLOAD;
                        end
                    end
                end
            end

            idw_pkg::ST_RATIO:
            begin
                div_q_next   = step_q;
                div_r_next   = step_r;
                div_cnt_next = div_cnt_reg - 7'd1;
                if (div_cnt_reg == 7'd1)
                begin
                    r_next     = (step_q[63:32] != 32'd0) ? idw_pkg::CAP32 : step_q[31:0];
                    state_next = idw_pkg::ST_POW_MUL;
                end
            end

            idw_pkg::ST_POW_MUL:
            begin
                if (k_reg == 3'd0)
                begin
                    state_next = idw_pkg::ST_WMUL;
                end
                else
                begin
                    prod_next  = mul_p[63:0];
                    state_next = idw_pkg::ST_POW_SCL;
                end
            end

            idw_pkg::ST_POW_SCL:
            begin
                w_next     = (scaled[63:32] != 32'd0) ? idw_pkg::CAP32 : scaled[31:0];
                k_next     = k_reg - 3'd1;
                state_next = idw_pkg::ST_POW_MUL;
            end

            idw_pkg::ST_WMUL:
            begin
                // A weight that has underflowed to zero counts as one LSB.
                w_next     = w_fix;
                prod_next  = mul_p[63:0];
                state_next = idw_pkg::ST_ACC;
            end

            idw_pkg::ST_ACC:
            begin
                wsum_next  = (wsum_add[64:63] != 2'b00) ? idw_pkg::SUM_MAX : wsum_add[63:0];
                if (vsum_add[64] != vsum_add[63])
                begin
                    vsum_next = vsum_add[64] ? idw_pkg::SUM_MIN : idw_pkg::SUM_MAX;
                end
                else
                begin
                    vsum_next = vsum_add[63:0];
                end
                count_next = count_reg + 7'd1;
                state_next = last_reg ? idw_pkg::ST_QLOAD : idw_pkg::ST_IDLE;
            end

            idw_pkg::ST_QLOAD:
            begin
                if (count_reg == 7'd0)
                begin
                    est_next     = 32'sd0;
                    used_next    = 7'd0;
                    nost_next    = 1'b1;
                    done_next    = 1'b1;
                    count_next   = 7'd0;
                    stopped_next = 1'b0;
                    wsum_next    = 64'd0;
                    vsum_next    = 64'd0;
                    state_next   = idw_pkg::ST_IDLE;
                end
                else
                begin
                    // Divide magnitudes and restore the sign at the end.
                    neg_next     = vsum_reg[63];
                    div_q_next   = mag;
                    div_r_next   = 64'd0;
                    div_d_next   = wsum_reg;
                    div_cnt_next = idw_pkg::QUOT_STEPS;
                    state_next   = idw_pkg::ST_QDIV;
                end
            end

            idw_pkg::ST_QDIV:
            begin
                div_q_next   = step_q;
                div_r_next   = step_r;
                div_cnt_next = div_cnt_reg - 7'd1;
                if (div_cnt_reg == 7'd1)
                begin
                    state_next = idw_pkg::ST_QOUT;
                end
            end

            idw_pkg::ST_QOUT:
            begin
                if (neg_reg)
                begin
                    if (div_q_reg > 64'h0000_0000_8000_0000)
                    begin
                        est_next = 32'sh8000_0000;
                    end
                    else
                    begin
                        est_next = $signed(32'd0 - div_q_reg[31:0]);
                    end
                end
                else
                begin
                    if (div_q_reg > 64'h0000_0000_7FFF_FFFF)
                    begin
                        est_next = 32'sh7FFF_FFFF;
                    end
                    else
                    begin
                        est_next = $signed(div_q_reg[31:0]);
                    end
                end
                used_next    = count_reg;
                nost_next    = 1'b0;
                done_next    = 1'b1;
                count_next   = 7'd0;
                stopped_next = 1'b0;
                wsum_next    = 64'd0;
                vsum_next    = 64'd0;
                state_next   = idw_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = idw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= idw_pkg::ST_IDLE;
            count_reg        <= 7'd0;
            stopped_reg      <= 1'b0;
            wsum_reg         <= 64'd0;
            vsum_reg         <= 64'd0;
            done_reg         <= 1'b0;
            max_count_reg    <= idw_pkg::MAX_COUNT_RST;
            max_distance_reg <= idw_pkg::MAX_DISTANCE_RST;
            exponent_reg     <= idw_pkg::EXPONENT_RST;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            stopped_reg <= stopped_next;
            wsum_reg    <= wsum_next;
            vsum_reg    <= vsum_next;
            done_reg    <= done_next;
            if (wr_en)
            begin
                case (wr_index)
                    idw_pkg::REG_MAX_COUNT:    max_count_reg    <= wr_data[6:0];
                    idw_pkg::REG_MAX_DISTANCE: max_distance_reg <= wr_data;
                    idw_pkg::REG_EXPONENT:     exponent_reg     <= wr_data[2:0];
                    default:                   max_count_reg    <= max_count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ion_reg     <= ion_next;
        last_reg    <= last_next;
        r_reg       <= r_next;
        w_reg       <= w_next;
        k_reg       <= k_next;
        prod_reg    <= prod_next;
        div_q_reg   <= div_q_next;
        div_r_reg   <= div_r_next;
        div_d_reg   <= div_d_next;
        div_cnt_reg <= div_cnt_next;
        neg_reg     <= neg_next;
        est_reg     <= est_next;
        used_reg    <= used_next;
        nost_reg    <= nost_next;
    end

    assign busy       = (state_reg != idw_pkg::ST_IDLE);
    assign done       = done_reg;
    assign estimate   = est_reg;
    assign used_count = used_reg;
    assign no_station = nost_reg;

endmodule

`default_nettype wire

[verif/inverse_distance_weighting_tb.sv]
`timescale 1ns / 1ps

module inverse_distance_weighting_tb;

    localparam int          FRAC          = 16;
    localparam int          RANDOM_ITEMS  = 600;
    localparam int          SETTLE_CYCLES = 130;
    localparam int          DRAIN_CYCLES  = 150;
    localparam logic [1:0]  REG_UNUSED    = 2'd3;

    typedef struct packed {
        logic signed [31:0] estimate;
        logic [6:0]         used_count;
        logic               no_station;
    } result_t;

    typedef enum {ROW_CONFIG, ROW_STATION} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  index;
        logic [31:0] word;
        logic [31:0] ion;
        logic        lst;
        bit          typed;
        result_t     want;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic        [31:0] distance = '0;
    logic signed [31:0] ion_value = '0;
    logic               last = 1'b0;
    logic               wr_en = 1'b0;
    logic        [1:0]  wr_index = '0;
    logic        [31:0] wr_data = '0;
    wire                busy;
    wire                done;
    wire signed  [31:0] estimate;
    wire         [6:0]  used_count;
    wire                no_station;

    inverse_distance_weighting dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .distance   (distance),
        .ion_value  (ion_value),
        .last       (last),
        .done       (done),
        .estimate   (estimate),
        .used_count (used_count),
        .no_station (no_station),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mirror of the register file and of the running interpolation.
    logic        [6:0]  cfg_max_count    = idw_pkg::MAX_COUNT_RST;
    logic        [31:0] cfg_max_distance = idw_pkg::MAX_DISTANCE_RST;
    logic        [2:0]  cfg_exponent     = idw_pkg::EXPONENT_RST;
    logic        [6:0]  run_count        = '0;
    logic               run_stopped      = 1'b0;
    logic        [63:0] run_weight_sum   = '0;
    logic signed [63:0] run_value_sum    = '0;

    result_t   pending_estimates[$];
    stim_row_t directed_rows[$];
    int        mismatch_count = 0;
    int        random_sent = 0;
    bit        steady_phase = 1'b0;
    bit        dirty = 1'b0;

    function automatic logic [31:0] station_weight(input logic [31:0] station_dist);
        logic [63:0] ratio;
        logic [63:0] w;
        int          k;
        int          i;
        if (station_dist == 32'd0)
        begin
            ratio = {32'd0, idw_pkg::CAP32};
        end
        else
        begin
            ratio = (64'd100 << (2 * FRAC)) / {32'd0, station_dist};
            if (ratio > {32'd0, idw_pkg::CAP32})
                ratio = {32'd0, idw_pkg::CAP32};
        end
        k = (cfg_exponent > idw_pkg::EXPONENT_MAX) ? int'(idw_pkg::EXPONENT_MAX)
                                                   : int'(cfg_exponent);
        w = 64'd1 << FRAC;
        for (i = 0; i < k; i++)
        begin
            w = (w * ratio) >> FRAC;
            if (w > {32'd0, idw_pkg::CAP32})
                w = {32'd0, idw_pkg::CAP32};
        end
        // A weight never vanishes, so an accepted station always counts.
        if (w == 64'd0)
            w = 64'd1;
        return w[31:0];
    endfunction

    // Advances the mirror by one station; returns 1 when a result is due.
    function automatic bit predict_station(input logic [31:0] station_dist,
                                           input logic [31:0] ion,
                                           input logic lst, output result_t res);
        logic        [6:0]  limit;
        logic        [31:0] w;
        logic signed [63:0] product;
        logic signed [64:0] total;
        logic signed [63:0] quot;
        res = '0;
        limit = (cfg_max_count > idw_pkg::MAX_STATIONS) ? idw_pkg::MAX_STATIONS
                                                        : cfg_max_count;
        if (!run_stopped)
        begin
            if (run_count >= limit || station_dist > cfg_max_distance)
            begin
                run_stopped = 1'b1;
            end
            else
            begin
                w = station_weight(station_dist);
                run_weight_sum = run_weight_sum + {32'd0, w};
                if (run_weight_sum > idw_pkg::SUM_MAX)
                    run_weight_sum = idw_pkg::SUM_MAX;
                product = $signed({32'd0, w}) * $signed({{32{ion[31]}}, ion});
                total = {run_value_sum[63], run_value_sum} + {product[63], product};
                if (total > $signed({1'b0, idw_pkg::SUM_MAX}))
                    run_value_sum = idw_pkg::SUM_MAX;
                else if (total < $signed({1'b1, idw_pkg::SUM_MIN}))
                    run_value_sum = idw_pkg::SUM_MIN;
                else
                    run_value_sum = total[63:0];
                run_count = run_count + 7'd1;
            end
        end
        if (!lst)
            return 1'b0;
        if (run_count != 7'd0 && run_weight_sum != 64'd0)
        begin
            quot = run_value_sum / $signed(run_weight_sum);
            if (quot > 64'sd2147483647)
                quot = 64'sd2147483647;
            else if (quot < -64'sd2147483648)
                quot = -64'sd2147483648;
            res.estimate   = quot[31:0];
            res.no_station = 1'b0;
        end
        else
        begin
            res.estimate   = '0;
            res.no_station = 1'b1;
        end
        res.used_count = run_count;
        run_count      = '0;
        run_stopped    = 1'b0;
        run_weight_sum = '0;
        run_value_sum  = '0;
        return 1'b1;
    endfunction

    function automatic void add_config(input logic [1:0] idx, input logic [31:0] data);
        stim_row_t row;
        row = '{ROW_CONFIG, idx, data, 32'd0, 1'b0, 1'b0, '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_station(input logic [31:0] station_dist, input logic [31:0] ion,
                                        input logic lst);
        stim_row_t row;
        row = '{ROW_STATION, 2'd0, station_dist, ion, lst, 1'b0, '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_checked(input logic [31:0] station_dist, input logic [31:0] ion,
                                        input logic lst, input logic [31:0] est,
                                        input logic [6:0] cnt, input logic nost);
        stim_row_t row;
        row = '{ROW_STATION, 2'd0, station_dist, ion, lst, 1'b1, '{est, cnt, nost}};
        directed_rows.push_back(row);
    endfunction

    function automatic void report_mismatch(input string what, input result_t want,
                                            input result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected est=%h cnt=%0d none=%b, got est=%h cnt=%0d none=%b",
                     $realtime, what, want.estimate, want.used_count, want.no_station,
                     got.estimate, got.used_count, got.no_station);
    endfunction

    function automatic logic [31:0] draw_ion();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'd0;
            3, 4:    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] draw_distance();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return $urandom_range(1, 255);
            2:       return $urandom_range(32'h100, 32'h1_0000);
            3, 4:    return $urandom_range(32'h1_0000, 32'h100_0000);
            5:       return $urandom_range(0, cfg_max_distance);
            default: return $urandom();
        endcase
    endfunction

    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(negedge clk);
        wr_en    <= 1'b0;
        case (idx)
            idw_pkg::REG_MAX_COUNT:    cfg_max_count    = data[6:0];
            idw_pkg::REG_MAX_DISTANCE: cfg_max_distance = data;
            idw_pkg::REG_EXPONENT:     cfg_exponent     = data[2:0];
            default:                   ;
        endcase
    endtask

    // Registers may only change once the block has finished every set.
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_estimates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        dirty = 1'b0;
    endtask

    task automatic send_station(input logic [31:0] station_dist, input logic [31:0] ion,
                                input logic lst, input bit typed, input result_t typed_res);
        int      gap;
        result_t res;
        gap = steady_phase ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start     <= 1'b1;
        distance  <= station_dist;
        ion_value <= ion;
        last      <= lst;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (predict_station(station_dist, ion, lst, res))
            pending_estimates.push_back(typed ? typed_res : res);
        dirty = 1'b1;
    endtask

    task automatic random_config(input bit all_regs);
        logic [6:0]  mc;
        logic [31:0] md;
        if (all_regs || $urandom_range(0, 2) != 0)
        begin
            case ($urandom_range(0, 9))
                0:       mc = 7'd0;
                1:       mc = 7'd1;
                2:       mc = idw_pkg::MAX_STATIONS;
                3:       mc = $urandom_range(65, 127);
                default: mc = $urandom_range(1, 12);
            endcase
            write_register(idw_pkg::REG_MAX_COUNT, ($urandom() & 32'hFFFF_FF80) | {25'd0, mc});
        end
        if (all_regs || $urandom_range(0, 2) != 0)
        begin
            case ($urandom_range(0, 5))
                0:       md = 32'd0;
                1:       md = $urandom();
                2:       md = $urandom_range(32'h1_0000, 32'h100_0000);
                default: md = 32'hFFFF_FFFF;
            endcase
            write_register(idw_pkg::REG_MAX_DISTANCE, md);
        end
        if (all_regs || $urandom_range(0, 2) != 0)
            write_register(idw_pkg::REG_EXPONENT,
                           ($urandom() & 32'hFFFF_FFF8) | $urandom_range(0, 7));
    endtask

    task automatic random_set();
        int          n;
        int          i;
        bit          sweep;
        logic [31:0] d;
        logic [32:0] next_d;
        sweep = ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 24) == 0)
            n = $urandom_range(60, 70);
        else
            n = sweep ? $urandom_range(1, 10) : $urandom_range(1, 6);
        d = draw_distance();
        for (i = 0; i < n; i++)
        begin
            send_station(d, draw_ion(), (i == n - 1), 1'b0, '0);
            random_sent++;
            // Well-formed sets walk outwards; the rest are scattered noise.
            if (sweep)
            begin
                next_d = {1'b0, d} + {1'b0, $urandom() >> $urandom_range(8, 31)};
                d = next_d[32] ? 32'hFFFF_FFFF : next_d[31:0];
            end
            else
            begin
                d = draw_distance();
            end
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && done)
        begin
            got.estimate   = estimate;
            got.used_count = used_count;
            got.no_station = no_station;
            if (pending_estimates.size() == 0)
            begin
                report_mismatch("unexpected result", '0, got);
            end
            else
            begin
                want = pending_estimates.pop_front();
                if (got !== want)
                    report_mismatch("wrong result", want, got);
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int phase;
        int sets;
        int s;
        stim_row_t row;

        // With one station the weight cancels, so the estimate is its own value.
        add_checked(32'h0001_0000, 32'h0001_0000, 1'b1, 32'h0001_0000, 7'd1, 1'b0);
        add_checked(32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 7'd1, 1'b0);
        add_checked(32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 32'h8000_0000, 7'd1, 1'b0);
        add_station(32'h0000_0001, 32'h0000_0000, 1'b0);
        add_station(32'h0000_0002, 32'hFFFF_FFFF, 1'b0);
        add_station(32'h0000_0003, 32'h0005_0000, 1'b1);
        // Bits above the register width are dropped, so this sets a limit of one.
        add_config(idw_pkg::REG_MAX_COUNT, 32'hFFFF_FF81);
        add_station(32'h0000_8000, 32'h0000_0005, 1'b0);
        add_checked(32'h0000_9000, 32'h0000_0007, 1'b1, 32'h0000_0005, 7'd1, 1'b0);
        add_config(idw_pkg::REG_MAX_COUNT, 32'd0);
        add_checked(32'h0001_0000, 32'h0000_1234, 1'b1, 32'd0, 7'd0, 1'b1);
        add_config(idw_pkg::REG_MAX_COUNT, 32'd127);
        add_config(idw_pkg::REG_MAX_DISTANCE, 32'h0002_0000);
        add_config(idw_pkg::REG_EXPONENT, 32'd0);
        add_station(32'h0001_0000, 32'h0003_0000, 1'b0);
        add_station(32'h0002_0000, 32'h0005_0000, 1'b0);
        add_checked(32'h0002_0001, 32'h0000_0009, 1'b1, 32'h0004_0000, 7'd2, 1'b0);
        // A first station beyond the limit shuts out the whole set.
        add_station(32'h0003_0000, 32'h0000_0011, 1'b0);
        add_checked(32'h0001_0000, 32'h0000_0004, 1'b1, 32'd0, 7'd0, 1'b1);
        add_config(idw_pkg::REG_MAX_DISTANCE, 32'd0);
        add_checked(32'h0000_0000, 32'h0000_007B, 1'b1, 32'h0000_007B, 7'd1, 1'b0);
        add_config(REG_UNUSED, 32'hFFFF_FFFF);
        add_config(idw_pkg::REG_MAX_DISTANCE, 32'hFFFF_FFFF);
        add_config(idw_pkg::REG_EXPONENT, 32'hFFFF_FFFF);
        add_config(idw_pkg::REG_MAX_COUNT, 32'd64);
        add_station(32'h0000_0100, 32'h7FFF_FFFF, 1'b0);
        add_station(32'h0000_0100, 32'h7FFF_FFFF, 1'b0);
        add_station(32'h0000_0200, 32'h1234_5678, 1'b1);
        add_station(32'h0000_0000, 32'h8000_0000, 1'b0);
        add_station(32'h0000_0000, 32'h8000_0000, 1'b0);
        add_station(32'h0000_0000, 32'h8000_0000, 1'b1);
        add_config(idw_pkg::REG_EXPONENT, 32'd1);
        add_station(32'h0001_0000, 32'h0000_03E8, 1'b0);
        add_station(32'h0004_0000, 32'hFFFF_FC18, 1'b1);
        add_config(idw_pkg::REG_EXPONENT, 32'd3);
        add_station(32'h0000_8000, 32'h0000_7FFF, 1'b0);
        add_station(32'h0000_C000, 32'h0000_0000, 1'b1);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_CONFIG)
            begin
                if (dirty)
                    settle();
                write_register(row.index, row.word);
            end
            else
            begin
                send_station(row.word, row.ion, row.lst, row.typed, row.want);
            end
        end

        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            settle();
            random_config(phase == 0);
            steady_phase = ($urandom_range(0, 3) == 0);
            sets = $urandom_range(1, 6);
            for (s = 0; s < sets; s++)
                random_set();
            phase++;
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending_estimates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/idw_pkg.sv
rtl/inverse_distance_weighting.sv
verif/inverse_distance_weighting_tb.sv
